/* rtl/lpht_pkg.sv */
// package: types, codes and constants for the linear probing hash table
package lpht_pkg;

	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned SIZE_W = IDX_W + 1;
	localparam int unsigned ENTRY_W = 16 + 32 + 32 + 32;

	typedef enum logic [2:0] {
		FN_INSERT   = 3'd0,
		FN_FIND     = 3'd1,
		FN_REMOVE   = 3'd2,
		FN_REM_POS  = 3'd3,
		FN_READ_POS = 3'd4,
		FN_NEXT_OCC = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_BADPOS   = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_FIND_RD,
		S_FIND_CHK,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_POS_RD,
		S_POS_CHK,
		S_NEXT_RD,
		S_NEXT_CHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] hash_main;
		logic [31:0] hash_a;
		logic [31:0] hash_b;
		logic [15:0] key_length;
		logic [9:0]  position;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  slot;
		logic [31:0] key_hash;
	} out_word_t;

endpackage

/* rtl/linear_probe_hash_table.sv */
// top level: linear probing hash table with slot memory and probe sequencer
//
// channel   direction  handshake          word
// in        input      in_valid/in_ready  lpht_pkg::in_word_t
// out       output     out_valid/out_ready lpht_pkg::out_word_t
// cfg       input      cfg_we             table_size, 11 bits
//
// one word at a time; the single-port slot memory is read, then checked, for each visited slot
// modulo: restoring shift-subtract for hash_main mod size
// insert: modulo, a find pass for a duplicate, then a probe pass from the home slot for an empty one
// reset: a clearing pass over all TABLE_DEPTH slots runs before the first word is taken
// a finished result sits in the output register; in_ready waits until it is taken
module linear_probe_hash_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lpht_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output lpht_pkg::out_word_t out_word,
	input  logic                cfg_we,
	input  logic [10:0]         cfg_data
);

	localparam int unsigned IW = lpht_pkg::IDX_W;
	localparam int unsigned SW = lpht_pkg::SIZE_W;

	logic [lpht_pkg::ENTRY_W-1:0] mem [lpht_pkg::TABLE_DEPTH];
	logic [lpht_pkg::ENTRY_W-1:0] rd_q;

	lpht_pkg::state_t state_q, state_d;
	lpht_pkg::in_word_t req_q;
	logic [10:0] size_cfg_q;
	logic [SW-1:0] size_q;
	logic [IW-1:0] ptr_q, ptr_d, start_q, start_d;
	logic [SW-1:0] cnt_q, cnt_d;
	logic [32:0] rem_q, rem_d;
	logic [31:0] quo_q, quo_d;
	logic [5:0] mcnt_q, mcnt_d;
	lpht_pkg::out_word_t res_q, res_d;
	logic out_valid_q, out_valid_d;

	logic mem_re, mem_we;
	logic [IW-1:0] mem_addr;
	logic [lpht_pkg::ENTRY_W-1:0] mem_wdata;

	logic [15:0] r_len;
	logic [31:0] r_hm, r_ha, r_hb;
	logic key_hit;
	logic [SW-1:0] eff_size;
	logic [IW-1:0] ptr_inc;
	logic [32:0] rem_sh;

	assign {r_len, r_hm, r_ha, r_hb} = rd_q;
	assign key_hit = (r_len == req_q.key_length) && (r_hm == req_q.hash_main)
		&& (r_ha == req_q.hash_a) && (r_hb == req_q.hash_b);

	always_comb begin
		if (size_cfg_q == 11'd0)
			eff_size = SW'(1);
		else if ({{(32-11){1'b0}}, size_cfg_q} > 32'(lpht_pkg::TABLE_DEPTH))
			eff_size = SW'(lpht_pkg::TABLE_DEPTH);
		else
			eff_size = SW'(size_cfg_q);
	end

	assign ptr_inc = ({1'b0, ptr_q} + SW'(1) >= size_q) ? '0 : ptr_q + IW'(1);
	assign rem_sh = {rem_q[31:0], quo_q[31]};

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpht_pkg::S_CLEAR;
			size_cfg_q  <= 11'd1024;
			ptr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ptr_q       <= ptr_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
			if (cfg_we)
				size_cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q  <= in_word;
			size_q <= eff_size;
		end
		start_q <= start_d;
		rem_q   <= rem_d;
		quo_q   <= quo_d;
		mcnt_q  <= mcnt_d;
		res_q   <= res_d;
	end

	always_comb begin
		state_d     = state_q;
		ptr_d       = ptr_q;
		start_d     = start_q;
		cnt_d       = cnt_q;
		rem_d       = rem_q;
		quo_d       = quo_q;
		mcnt_d      = mcnt_q;
		res_d       = res_q;
		out_valid_d = out_valid_q;
		in_ready    = 1'b0;
		mem_re      = 1'b0;
		mem_we      = 1'b0;
		mem_addr    = ptr_q;
		mem_wdata   = '0;
		if (out_valid_q && out_ready)
			out_valid_d = 1'b0;
		case (state_q)
			lpht_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				ptr_d  = ptr_q + IW'(1);
				if (ptr_q == IW'(lpht_pkg::TABLE_DEPTH - 1))
					state_d = lpht_pkg::S_IDLE;
			end
			lpht_pkg::S_IDLE: begin
				in_ready = !out_valid_q;
				if (in_valid && in_ready) begin
					res_d = '{status: lpht_pkg::ST_NOTFOUND, slot: '0, key_hash: '0};
					rem_d = '0;
					quo_d = in_word.hash_main;
					mcnt_d = '0;
					ptr_d = in_word.position;
					case (in_word.func)
						lpht_pkg::FN_INSERT, lpht_pkg::FN_FIND, lpht_pkg::FN_REMOVE: begin
							if (in_word.key_length == 16'd0)
								state_d = lpht_pkg::S_DONE;
							else
								state_d = lpht_pkg::S_MOD;
						end
						lpht_pkg::FN_REM_POS, lpht_pkg::FN_READ_POS: begin
							res_d.slot = in_word.position;
							if ({1'b0, in_word.position} >= eff_size) begin
								res_d.status = lpht_pkg::ST_BADPOS;
								state_d = lpht_pkg::S_DONE;
							end else
								state_d = lpht_pkg::S_POS_RD;
						end
						lpht_pkg::FN_NEXT_OCC: begin
							if ({1'b0, in_word.position} >= eff_size)
								state_d = lpht_pkg::S_DONE;
							else
								state_d = lpht_pkg::S_NEXT_RD;
						end
						default: begin
							res_d.status = lpht_pkg::ST_BADPOS;
							state_d = lpht_pkg::S_DONE;
						end
					endcase
				end
			end
			lpht_pkg::S_MOD: begin
				// restoring division, one quotient bit per cycle
				if (rem_sh >= {{(33-SW){1'b0}}, size_q}) begin
					rem_d = rem_sh - {{(33-SW){1'b0}}, size_q};
					quo_d = {quo_q[30:0], 1'b1};
				end else begin
					rem_d = rem_sh;
					quo_d = {quo_q[30:0], 1'b0};
				end
				mcnt_d = mcnt_q + 6'd1;
				if (mcnt_q == 6'd31) begin
					state_d = lpht_pkg::S_FIND_RD;
					ptr_d   = rem_d[IW-1:0];
					start_d = rem_d[IW-1:0];
					cnt_d   = '0;
				end
			end
			lpht_pkg::S_FIND_RD: begin
				mem_re  = 1'b1;
				state_d = lpht_pkg::S_FIND_CHK;
			end
			lpht_pkg::S_FIND_CHK: begin
				if (key_hit) begin
					res_d.slot = ptr_q;
					if (req_q.func == lpht_pkg::FN_INSERT)
						res_d.status = lpht_pkg::ST_DUP;
					else
						res_d.status = lpht_pkg::ST_OK;
					if (req_q.func == lpht_pkg::FN_REMOVE)
						mem_we = 1'b1;
					state_d = lpht_pkg::S_DONE;
				end else if (cnt_q + SW'(1) >= size_q) begin
					if (req_q.func == lpht_pkg::FN_INSERT) begin
						ptr_d   = start_q;
						cnt_d   = '0;
						state_d = lpht_pkg::S_PROBE_RD;
					end else
						state_d = lpht_pkg::S_DONE;
				end else begin
					ptr_d   = ptr_inc;
					cnt_d   = cnt_q + SW'(1);
					state_d = lpht_pkg::S_FIND_RD;
				end
			end
			lpht_pkg::S_PROBE_RD: begin
				mem_re  = 1'b1;
				state_d = lpht_pkg::S_PROBE_CHK;
			end
			lpht_pkg::S_PROBE_CHK: begin
				if (r_len == 16'd0) begin
					mem_we    = 1'b1;
					mem_wdata = {req_q.key_length, req_q.hash_main, req_q.hash_a,
						req_q.hash_b};
					res_d.status = lpht_pkg::ST_OK;
					res_d.slot   = ptr_q;
					state_d = lpht_pkg::S_DONE;
				end else if (cnt_q + SW'(1) >= size_q) begin
					res_d.status = lpht_pkg::ST_FULL;
					state_d = lpht_pkg::S_DONE;
				end else begin
					ptr_d   = ptr_inc;
					cnt_d   = cnt_q + SW'(1);
					state_d = lpht_pkg::S_PROBE_RD;
				end
			end
			lpht_pkg::S_POS_RD: begin
				if (req_q.func == lpht_pkg::FN_REM_POS) begin
					mem_we = 1'b1;
					res_d.status = lpht_pkg::ST_OK;
					state_d = lpht_pkg::S_DONE;
				end else begin
					mem_re  = 1'b1;
					state_d = lpht_pkg::S_POS_CHK;
				end
			end
			lpht_pkg::S_POS_CHK: begin
				if (r_len == 16'd0)
					res_d.status = lpht_pkg::ST_EMPTY;
				else begin
					res_d.status   = lpht_pkg::ST_OK;
					res_d.key_hash = r_hm;
				end
				state_d = lpht_pkg::S_DONE;
			end
			lpht_pkg::S_NEXT_RD: begin
				mem_re  = 1'b1;
				state_d = lpht_pkg::S_NEXT_CHK;
			end
			lpht_pkg::S_NEXT_CHK: begin
				if (r_len != 16'd0) begin
					res_d.status = lpht_pkg::ST_OK;
					res_d.slot   = ptr_q;
					state_d = lpht_pkg::S_DONE;
				end else if ({1'b0, ptr_q} + SW'(1) >= size_q)
					state_d = lpht_pkg::S_DONE;
				else begin
					ptr_d   = ptr_q + IW'(1);
					state_d = lpht_pkg::S_NEXT_RD;
				end
			end
			lpht_pkg::S_DONE: begin
				out_valid_d = 1'b1;
				state_d = lpht_pkg::S_IDLE;
			end
			default: state_d = lpht_pkg::S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word  = res_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == lpht_pkg::S_IDLE) && !out_valid_q)
		else $error("ready outside idle");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpht_pkg::S_DONE) |=> out_valid)
		else $error("result not presented");
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("read and write together");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpht_pkg::S_FIND_CHK || state_q == lpht_pkg::S_PROBE_CHK)
		|-> ({1'b0, ptr_q} < size_q))
		else $error("probe pointer beyond size");

endmodule

/* tb/linear_probe_hash_table_tb.sv */
// testbench: linear probing hash table checked against a slot-table predictor
module linear_probe_hash_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int CFG_QUIET = 8;

	typedef struct {
		bit         is_cfg;
		logic [10:0] size;
		lpht_pkg::in_word_t word;
	} job_t;

	typedef struct {
		logic [31:0] hm;
		logic [31:0] ha;
		logic [31:0] hb;
		logic [15:0] len;
	} key_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	lpht_pkg::in_word_t in_word = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	lpht_pkg::out_word_t out_word;
	logic      cfg_we = 1'b0;
	logic [10:0] cfg_data = '0;

	job_t      pending_jobs[$];
	lpht_pkg::out_word_t expected_results[$];
	int        issued = 0;
	int        accepted = 0;
	int        quiet = 0;
	int        watchdog = 0;
	bit        failed = 1'b0;

	logic [10:0] mdl_size;
	logic [15:0] mdl_len[lpht_pkg::TABLE_DEPTH];
	logic [31:0] mdl_hm[lpht_pkg::TABLE_DEPTH];
	logic [31:0] mdl_ha[lpht_pkg::TABLE_DEPTH];
	logic [31:0] mdl_hb[lpht_pkg::TABLE_DEPTH];

	linear_probe_hash_table u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned active_size();
		int unsigned s;
		s = mdl_size;
		if (s == 0) s = 1;
		if (s > lpht_pkg::TABLE_DEPTH) s = lpht_pkg::TABLE_DEPTH;
		return s;
	endfunction

	function automatic bit table_lookup(lpht_pkg::in_word_t w, int unsigned sz,
		output int unsigned at);
		int unsigned start;
		int unsigned p;
		start = w.hash_main % sz;
		p = start;
		at = 0;
		do begin
			if (mdl_ha[p] == w.hash_a && mdl_hb[p] == w.hash_b && mdl_hm[p] == w.hash_main
				&& mdl_len[p] == w.key_length) begin
				at = p;
				return 1'b1;
			end
			p = (p + 1) % sz;
		end while (p != start);
		return 1'b0;
	endfunction

	function automatic void clear_entry(int unsigned i);
		mdl_len[i] = '0;
		mdl_hm[i] = '0;
		mdl_ha[i] = '0;
		mdl_hb[i] = '0;
	endfunction

	function automatic lpht_pkg::out_word_t table_apply(lpht_pkg::in_word_t w);
		lpht_pkg::out_word_t r;
		int unsigned sz;
		int unsigned at;
		int unsigned start;
		int unsigned p;
		sz = active_size();
		r.status = lpht_pkg::ST_NOTFOUND;
		r.slot = '0;
		r.key_hash = '0;
		case (w.func)
			lpht_pkg::FN_INSERT: begin
				if (w.key_length != 0) begin
					if (table_lookup(w, sz, at)) begin
						r.status = lpht_pkg::ST_DUP;
						r.slot = 10'(at);
					end else begin
						r.status = lpht_pkg::ST_FULL;
						start = w.hash_main % sz;
						p = start;
						do begin
							if (mdl_len[p] == 0) begin
								mdl_len[p] = w.key_length;
								mdl_hm[p] = w.hash_main;
								mdl_ha[p] = w.hash_a;
								mdl_hb[p] = w.hash_b;
								r.status = lpht_pkg::ST_OK;
								r.slot = 10'(p);
								break;
							end
							p = (p + 1) % sz;
						end while (p != start);
					end
				end
			end
			lpht_pkg::FN_FIND, lpht_pkg::FN_REMOVE: begin
				if (w.key_length != 0 && table_lookup(w, sz, at)) begin
					r.status = lpht_pkg::ST_OK;
					r.slot = 10'(at);
					if (w.func == lpht_pkg::FN_REMOVE) clear_entry(at);
				end
			end
			lpht_pkg::FN_REM_POS: begin
				r.slot = w.position;
				if (w.position >= sz) r.status = lpht_pkg::ST_BADPOS;
				else begin
					clear_entry(w.position);
					r.status = lpht_pkg::ST_OK;
				end
			end
			lpht_pkg::FN_READ_POS: begin
				r.slot = w.position;
				if (w.position >= sz) r.status = lpht_pkg::ST_BADPOS;
				else if (mdl_len[w.position] == 0) r.status = lpht_pkg::ST_EMPTY;
				else begin
					r.status = lpht_pkg::ST_OK;
					r.key_hash = mdl_hm[w.position];
				end
			end
			lpht_pkg::FN_NEXT_OCC: begin
				for (int unsigned i = w.position; i < sz; i++) begin
					if (mdl_len[i] != 0) begin
						r.status = lpht_pkg::ST_OK;
						r.slot = 10'(i);
						break;
					end
				end
			end
			default: r.status = lpht_pkg::ST_BADPOS;
		endcase
		return r;
	endfunction

	task automatic push_op(logic [2:0] f, key_t k, logic [9:0] pos);
		job_t j;
		j.is_cfg = 1'b0;
		j.size = '0;
		j.word.func = f;
		j.word.hash_main = k.hm;
		j.word.hash_a = k.ha;
		j.word.hash_b = k.hb;
		j.word.key_length = k.len;
		j.word.position = pos;
		pending_jobs.push_back(j);
	endtask

	task automatic push_cfg(logic [10:0] sz);
		job_t j;
		j.is_cfg = 1'b1;
		j.size = sz;
		j.word = '0;
		pending_jobs.push_back(j);
	endtask

	function automatic key_t rand_key();
		key_t k;
		k.hm = $urandom;
		k.ha = $urandom;
		k.hb = $urandom;
		k.len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
		return k;
	endfunction

	function automatic bit calm();
		return accepted >= 120 && accepted < 170;
	endfunction

	// driver
	always @(negedge clk) begin
		logic nv;
		logic nwe;
		job_t nj;
		if (arst_n) begin
			nv = 1'b0;
			nwe = 1'b0;
			quiet <= (expected_results.size() == 0 && issued == accepted) ? quiet + 1 : 0;
			if (in_valid && issued != accepted) begin
				nv = 1'b1;
			end else if (pending_jobs.size() > 0) begin
				if (pending_jobs[0].is_cfg) begin
					if (expected_results.size() == 0 && issued == accepted && quiet >= CFG_QUIET
						&& !cfg_we) begin
						cfg_data <= pending_jobs[0].size;
						nwe = 1'b1;
						void'(pending_jobs.pop_front());
					end
				end else if (calm() || $urandom_range(99) >= 37) begin
					nj = pending_jobs.pop_front();
					in_word <= nj.word;
					nv = 1'b1;
					issued <= issued + 1;
				end
			end
			in_valid <= nv;
			cfg_we <= nwe;
			out_ready <= calm() || $urandom_range(99) >= 37;
		end
	end

	// monitor
	always @(posedge clk) begin
		lpht_pkg::out_word_t exp_w;
		bit active;
		active = 1'b0;
		if (arst_n) begin
			if (cfg_we) begin
				mdl_size = cfg_data;
				active = 1'b1;
			end
			if (in_valid && in_ready) begin
				expected_results.push_back(table_apply(in_word));
				accepted <= accepted + 1;
				active = 1'b1;
			end
			if (out_valid && out_ready) begin
				active = 1'b1;
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected");
					failed = 1'b1;
				end else begin
					exp_w = expected_results.pop_front();
					if (out_word.status !== exp_w.status) begin
						$error("status expected %0d actual %0d", exp_w.status, out_word.status);
						failed = 1'b1;
					end
					if (out_word.slot !== exp_w.slot) begin
						$error("slot expected %0d actual %0d", exp_w.slot, out_word.slot);
						failed = 1'b1;
					end
					if (out_word.key_hash !== exp_w.key_hash) begin
						$error("key_hash expected %h actual %h", exp_w.key_hash, out_word.key_hash);
						failed = 1'b1;
					end
				end
			end
			watchdog <= active ? 0 : watchdog + 1;
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("linear_probe_hash_table: mismatch");
				$finish;
			end
		end
	end

	initial begin
		key_t ka;
		key_t kb;
		key_t kz;
		key_t pool[6];
		logic [10:0] sizes[10];
		int unsigned sz;
		int unsigned n;
		mdl_size = 11'd1024;
		for (int i = 0; i < lpht_pkg::TABLE_DEPTH; i++) clear_entry(i);

		// directed at reset size
		ka = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1};
		kb = '{32'h0, 32'h0, 32'h0, 16'hFFFF};
		kz = '{32'h0, 32'h0, 32'h0, 16'd0};
		push_op(lpht_pkg::FN_INSERT, ka, 10'd0);
		push_op(lpht_pkg::FN_INSERT, ka, 10'd0);
		push_op(lpht_pkg::FN_INSERT, kb, 10'd0);
		push_op(lpht_pkg::FN_FIND, ka, 10'd0);
		push_op(lpht_pkg::FN_INSERT, kz, 10'd0);
		push_op(lpht_pkg::FN_FIND, kz, 10'd0);
		push_op(lpht_pkg::FN_REMOVE, kz, 10'd0);
		push_op(lpht_pkg::FN_READ_POS, kz, 10'd1023);
		push_op(lpht_pkg::FN_NEXT_OCC, kz, 10'd1);
		push_op(lpht_pkg::FN_READ_POS, kz, 10'd7);
		push_op(lpht_pkg::FN_REM_POS, kz, 10'd7);
		push_op(3'd6, ka, 10'd3);
		push_op(3'd7, ka, 10'd3);
		push_op(lpht_pkg::FN_REMOVE, ka, 10'd0);
		push_op(lpht_pkg::FN_REMOVE, ka, 10'd0);
		push_op(lpht_pkg::FN_REM_POS, kz, 10'd0);
		// small table: fill up, then out-of-range positions
		push_cfg(11'd5);
		for (int i = 0; i < 6; i++)
			push_op(lpht_pkg::FN_INSERT, '{32'd3, 32'(i), 32'd9, 16'd4}, 10'd0);
		push_op(lpht_pkg::FN_READ_POS, kz, 10'd7);
		push_op(lpht_pkg::FN_REM_POS, kz, 10'd9);
		push_op(lpht_pkg::FN_NEXT_OCC, kz, 10'd7);
		push_cfg(11'd0);
		push_op(lpht_pkg::FN_INSERT, kb, 10'd0);
		push_op(lpht_pkg::FN_NEXT_OCC, kz, 10'd0);
		push_cfg(11'd2047);
		push_op(lpht_pkg::FN_FIND, kb, 10'd0);

		// random phases
		sizes = '{11'd1, 11'd2, 11'd3, 11'd4, 11'd7, 11'd8, 11'd13, 11'd16, 11'd31, 11'd64};
		n = 0;
		while (n < 250) begin
			if ($urandom_range(9) == 0) begin
				sz = ($urandom_range(1) == 0) ? 1024 : 2047;
				push_cfg(11'(sz));
				sz = 1024;
			end else begin
				sz = sizes[$urandom_range(9)];
				push_cfg(11'(sz));
			end
			foreach (pool[i]) pool[i] = rand_key();
			for (int i = 0; i < ((sz >= 1024) ? 3 : 25); i++) begin
				key_t k;
				logic [9:0] pos;
				k = pool[$urandom_range(5)];
				if ($urandom_range(19) == 0) k = rand_key();
				if ($urandom_range(29) == 0) k.len = 16'd0;
				pos = ($urandom_range(5) == 0) ? 10'($urandom) : 10'($urandom_range(sz + 1));
				case ($urandom_range(19))
					0,1,2,3,4,5,6: push_op(lpht_pkg::FN_INSERT, k, pos);
					7,8,9:         push_op(lpht_pkg::FN_FIND, k, pos);
					10,11:         push_op(lpht_pkg::FN_REMOVE, k, pos);
					12,13:         push_op(lpht_pkg::FN_REM_POS, k, pos);
					14,15,16:      push_op(lpht_pkg::FN_READ_POS, k, pos);
					17,18:         push_op(lpht_pkg::FN_NEXT_OCC, k, pos);
					default:       push_op(3'($urandom_range(6, 7)), k, pos);
				endcase
				n++;
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (!(pending_jobs.size() == 0 && issued == accepted
			&& expected_results.size() == 0))
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (!failed && expected_results.size() == 0) begin
			$display("linear_probe_hash_table: match");
		end else begin
			$display("linear_probe_hash_table: mismatch");
		end
		$finish;
	end
endmodule
